### hdl/i2c_master_bit_engine_assert.svh
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_assert.svh
// Assertion macros shared by the bit engine modules.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define I2CBE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c bit engine check failed");

// Next-cycle implication.
`define I2CBE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c bit engine check failed");

`else

`define I2CBE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define I2CBE_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Types, codes and sizes shared by the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = 16;
   localparam int POLL_W  = 8;
   localparam int STEP_W  = 5;
   localparam int BIT_W   = 3;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_TICKS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_POLL_LIMIT = 1'd1;
   localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST    = 16'd1;
   localparam logic [POLL_W-1:0]    ACK_POLL_LIMIT_RST = 8'd100;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_WAIT_ACK  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SEND_ACK  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SEND_NACK = 3'd7;

   // sequencer steps
   localparam logic [STEP_W-1:0] ST_IDLE         = 5'd0;
   localparam logic [STEP_W-1:0] ST_START_SDA_HI = 5'd1;
   localparam logic [STEP_W-1:0] ST_START_SCL_HI = 5'd2;
   localparam logic [STEP_W-1:0] ST_START_SDA_LO = 5'd3;
   localparam logic [STEP_W-1:0] ST_START_SCL_LO = 5'd4;
   localparam logic [STEP_W-1:0] ST_STOP_SDA_LO  = 5'd5;
   localparam logic [STEP_W-1:0] ST_STOP_SCL_HI  = 5'd6;
   localparam logic [STEP_W-1:0] ST_STOP_SDA_HI  = 5'd7;
   localparam logic [STEP_W-1:0] ST_ACK_DRIVE    = 5'd8;
   localparam logic [STEP_W-1:0] ST_ACK_SCL_HI   = 5'd9;
   localparam logic [STEP_W-1:0] ST_ACK_SCL_LO   = 5'd10;
   localparam logic [STEP_W-1:0] ST_WAIT_RAISE   = 5'd11;
   localparam logic [STEP_W-1:0] ST_WAIT_POLL    = 5'd12;
   localparam logic [STEP_W-1:0] ST_WR_DATA      = 5'd13;
   localparam logic [STEP_W-1:0] ST_WR_SCL_HI    = 5'd14;
   localparam logic [STEP_W-1:0] ST_WR_SCL_LO    = 5'd15;
   localparam logic [STEP_W-1:0] ST_RD_SCL_LO    = 5'd16;
   localparam logic [STEP_W-1:0] ST_RD_SAMPLE    = 5'd17;
   localparam logic [STEP_W-1:0] ST_FINISH       = 5'd18;

   localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

   // one classified tick, as it waits in the queue
   typedef struct packed {
      logic              has_cmd;
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] write_data;
      logic              ack_after_read;
      logic              sda_in;
   } q_entry_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_ticks;
      logic [POLL_W-1:0]  ack_poll_limit;
   } cfg_type;

   // queue status toward the front end
   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

### hdl/i2cbe_req_if.sv
// ----------------------------------------------------------------------------
// i2cbe_req_if
// Tick channel into the bit engine: command fields and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cbe_req_if;
   logic                            valid;
   logic                            ready;
   logic [i2cbe_pkg::CMD_W-1:0]     command;
   logic [i2cbe_pkg::BYTE_W-1:0]    write_data;
   logic                            ack_after_read;
   logic                            sda_in;

   modport source (output valid, command, write_data, ack_after_read, sda_in,
                   input ready);
   modport sink (input valid, command, write_data, ack_after_read, sda_in,
                 output ready);
endinterface

### hdl/i2cbe_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cbe_rsp_if
// Result channel out of the bit engine: bus levels and status per tick.
// ----------------------------------------------------------------------------
interface i2cbe_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            scl_level;
   logic                            sda_level;
   logic                            busy_res;
   logic                            done_res;
   logic [i2cbe_pkg::BYTE_W-1:0]    read_data;
   logic                            ack_timeout;

   modport source (output valid, scl_level, sda_level, busy_res, done_res,
                   read_data, ack_timeout, input ready);
   modport sink (input valid, scl_level, sda_level, busy_res, done_res,
                 read_data, ack_timeout, output ready);
endinterface

### hdl/i2cbe_front.sv
// ----------------------------------------------------------------------------
// i2cbe_front
// Accept ticks, classify the command and push them into the queue.
// ----------------------------------------------------------------------------
module i2cbe_front import i2cbe_pkg::*; (
   i2cbe_req_if.sink     req_ch,
   input  q_status_type  q_status,
   output logic          push,
   output q_entry_type   push_entry
);

   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && !q_status.full;

   always_comb begin
      push_entry.has_cmd        = (req_ch.command != CMD_NONE);
      push_entry.command        = req_ch.command;
      push_entry.write_data     = req_ch.write_data;
      push_entry.ack_after_read = req_ch.ack_after_read;
      push_entry.sda_in         = req_ch.sda_in;
   end

endmodule

### hdl/i2cbe_queue.sv
// ----------------------------------------------------------------------------
// i2cbe_queue
// Short FIFO of classified ticks between front and back end.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2cbe_queue import i2cbe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  q_entry_type   push_entry,
   input  logic          pop,
   output q_status_type  q_status,
   output q_entry_type   head
);

   q_entry_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.valid = (cnt_ff != '0);
   assign q_status.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));

   `I2CBE_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, cnt_ff != '0)
   `I2CBE_ASSERT_IMP(a_no_push_full, clock, reset, push, cnt_ff != QCNT_W'(QUEUE_DEPTH))

endmodule

### hdl/i2cbe_back.sv
// ----------------------------------------------------------------------------
// i2cbe_back
// Bus sequencer: one tick per queue entry, result held in an output register.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2cbe_back import i2cbe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_valid,
   input  q_entry_type   head,
   output logic          pop,
   i2cbe_rsp_if.source   rsp_ch
);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [POLL_W-1:0]  poll_ff, poll_in;
   logic               scl_drv_ff, scl_drv_in;
   logic               sda_drv_ff, sda_drv_in;
   logic               ackc_ff, ackc_in;
   logic               tmo_ff, tmo_in;
   logic [BYTE_W-1:0]  rbyte_ff, rbyte_in;
   logic               done;
   logic               run;
   logic [PHASE_W-1:0] dly;

   logic               rsp_valid_ff;
   logic               rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_tmo_ff;
   logic [BYTE_W-1:0]  rsp_rdata_ff;

   // take a tick when the output slot is free or drains this cycle
   assign pop = q_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign dly = (cfg.phase_ticks != '0) ? cfg.phase_ticks : PHASE_W'(1);

   always_comb begin
      step_in    = step_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      phase_in   = phase_ff;
      poll_in    = poll_ff;
      scl_drv_in = scl_drv_ff;
      sda_drv_in = sda_drv_ff;
      ackc_in    = ackc_ff;
      tmo_in     = tmo_ff;
      rbyte_in   = rbyte_ff;
      done       = 1'b0;
      run        = 1'b0;
      if (pop) begin
         if (step_ff == ST_IDLE) begin
            if (head.has_cmd) begin
               run    = 1'b1;
               bit_in = '0;
               poll_in = '0;
               case (head.command)
                  CMD_START: begin
                     step_in = ST_START_SDA_HI;
                  end
                  CMD_STOP: begin
                     step_in = ST_STOP_SDA_LO;
                  end
                  CMD_WRITE: begin
                     shift_in = head.write_data;
                     step_in  = ST_WR_DATA;
                  end
                  CMD_READ: begin
                     shift_in   = '0;
                     ackc_in    = head.ack_after_read;
                     sda_drv_in = 1'b1;
                     step_in    = ST_RD_SCL_LO;
                  end
                  CMD_WAIT_ACK: begin
                     tmo_in  = 1'b0;
                     step_in = ST_WAIT_RAISE;
                  end
                  CMD_SEND_ACK: begin
                     ackc_in = 1'b1;
                     step_in = ST_ACK_DRIVE;
                  end
                  default: begin
                     ackc_in = 1'b0;
                     step_in = ST_ACK_DRIVE;
                  end
               endcase
            end
         end else begin
            phase_in = (phase_ff != '0) ? phase_ff - 1'b1 : '0;
            run      = (phase_in == '0);
         end

         if (run) begin
            case (step_in)
               ST_START_SDA_HI: begin
                  sda_drv_in = 1'b1; step_in = ST_START_SCL_HI; phase_in = dly;
               end
               ST_START_SCL_HI: begin
                  scl_drv_in = 1'b1; step_in = ST_START_SDA_LO; phase_in = dly;
               end
               ST_START_SDA_LO: begin
                  sda_drv_in = 1'b0; step_in = ST_START_SCL_LO; phase_in = dly;
               end
               ST_START_SCL_LO: begin
                  scl_drv_in = 1'b0; step_in = ST_FINISH; phase_in = dly;
               end
               ST_STOP_SDA_LO: begin
                  sda_drv_in = 1'b0; step_in = ST_STOP_SCL_HI; phase_in = dly;
               end
               ST_STOP_SCL_HI: begin
                  scl_drv_in = 1'b1; step_in = ST_STOP_SDA_HI; phase_in = dly;
               end
               ST_STOP_SDA_HI: begin
                  sda_drv_in = 1'b1; step_in = ST_FINISH; phase_in = dly;
               end
               ST_ACK_DRIVE: begin
                  scl_drv_in = 1'b0;
                  sda_drv_in = !ackc_in;
                  step_in    = ST_ACK_SCL_HI;
                  phase_in   = dly;
               end
               ST_ACK_SCL_HI: begin
                  scl_drv_in = 1'b1; step_in = ST_ACK_SCL_LO; phase_in = dly;
               end
               ST_ACK_SCL_LO: begin
                  scl_drv_in = 1'b0; step_in = ST_IDLE; phase_in = '0; done = 1'b1;
               end
               ST_WAIT_RAISE: begin
                  sda_drv_in = 1'b1;
                  scl_drv_in = 1'b1;
                  step_in    = ST_WAIT_POLL;
                  phase_in   = dly;
               end
               ST_WAIT_POLL: begin
                  if (!head.sda_in) begin
                     scl_drv_in = 1'b0;
                     tmo_in     = 1'b0;
                     step_in    = ST_IDLE;
                     phase_in   = '0;
                     done       = 1'b1;
                  end else if (poll_in == cfg.ack_poll_limit) begin
                     // no ACK: drive the stop sequence from SDA low onward
                     tmo_in     = 1'b1;
                     sda_drv_in = 1'b0;
                     step_in    = ST_STOP_SCL_HI;
                     phase_in   = dly;
                  end else begin
                     poll_in  = poll_in + 1'b1;
                     phase_in = PHASE_W'(1);
                  end
               end
               ST_WR_DATA: begin
                  scl_drv_in = 1'b0;
                  sda_drv_in = shift_in[BYTE_W-1];
                  shift_in   = {shift_in[BYTE_W-2:0], 1'b0};
                  step_in    = ST_WR_SCL_HI;
                  phase_in   = dly;
               end
               ST_WR_SCL_HI: begin
                  scl_drv_in = 1'b1; step_in = ST_WR_SCL_LO; phase_in = dly;
               end
               ST_WR_SCL_LO: begin
                  scl_drv_in = 1'b0;
                  phase_in   = dly;
                  if (bit_in == LAST_BIT) begin
                     step_in = ST_FINISH;
                  end else begin
                     bit_in  = bit_in + 1'b1;
                     step_in = ST_WR_DATA;
                  end
               end
               ST_RD_SCL_LO: begin
                  scl_drv_in = 1'b0; step_in = ST_RD_SAMPLE; phase_in = dly;
               end
               ST_RD_SAMPLE: begin
                  scl_drv_in = 1'b1;
                  shift_in   = {shift_in[BYTE_W-2:0], head.sda_in};
                  phase_in   = dly;
                  if (bit_in == LAST_BIT) begin
                     rbyte_in = shift_in;
                     step_in  = ST_ACK_DRIVE;
                  end else begin
                     bit_in  = bit_in + 1'b1;
                     step_in = ST_RD_SCL_LO;
                  end
               end
               ST_FINISH: begin
                  step_in = ST_IDLE; phase_in = '0; done = 1'b1;
               end
               default: begin
                  step_in  = ST_IDLE;
                  phase_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_IDLE;
         bit_ff     <= '0;
         shift_ff   <= '0;
         phase_ff   <= '0;
         poll_ff    <= '0;
         scl_drv_ff <= 1'b1;
         sda_drv_ff <= 1'b1;
         ackc_ff    <= 1'b0;
         tmo_ff     <= 1'b0;
         rbyte_ff   <= '0;
      end else begin
         step_ff    <= step_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         phase_ff   <= phase_in;
         poll_ff    <= poll_in;
         scl_drv_ff <= scl_drv_in;
         sda_drv_ff <= sda_drv_in;
         ackc_ff    <= ackc_in;
         tmo_ff     <= tmo_in;
         rbyte_ff   <= rbyte_in;
      end
   end

   // output slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_scl_ff   <= scl_drv_in;
         rsp_sda_ff   <= sda_drv_in;
         rsp_busy_ff  <= (step_in != ST_IDLE);
         rsp_done_ff  <= done;
         rsp_rdata_ff <= rbyte_in;
         rsp_tmo_ff   <= tmo_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.scl_level   = rsp_scl_ff;
   assign rsp_ch.sda_level   = rsp_sda_ff;
   assign rsp_ch.busy_res    = rsp_busy_ff;
   assign rsp_ch.done_res    = rsp_done_ff;
   assign rsp_ch.read_data   = rsp_rdata_ff;
   assign rsp_ch.ack_timeout = rsp_tmo_ff;

   `I2CBE_ASSERT_IMP(a_idle_no_phase, clock, reset, step_ff == ST_IDLE, phase_ff == '0)
   `I2CBE_ASSERT_IMP(a_done_idle, clock, reset, pop && done, step_in == ST_IDLE)
   `I2CBE_ASSERT_IMP(a_tmo_stop, clock, reset, $rose(tmo_ff), step_ff == ST_STOP_SCL_HI)

endmodule

### hdl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: one bus tick per item, start/stop/byte/ack sequences.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_ch    in         valid/ready          command, write_data,
//                                             ack_after_read, sda_in
//   rsp_ch    out        valid/ready          scl_level, sda_level, busy_res,
//                                             done_res, read_data, ack_timeout
//   csr_*     in         csr_we (no ready)    csr_index, csr_wdata
//
// Each item is one bus tick and yields exactly one result item. The engine
// takes one item per clock while rsp_ch is not stalled; the back end handles
// each popped entry in one sequencer pass. An accepted item is registered
// in the queue entry and then in the output slot. Synchronous reset returns
// both lines to released, the sequencer to idle and the registers to
// phase_ticks 1, ack_poll_limit 100. A stalled result channel first fills
// the output slot, then the two-entry queue, and only then drops req_ch.ready.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine import i2cbe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   i2cbe_req_if.sink             req_ch,
   i2cbe_rsp_if.source           rsp_ch
);

   logic [PHASE_W-1:0] phase_ticks_ff;
   logic [POLL_W-1:0]  ack_poll_limit_ff;
   cfg_type            cfg;

   logic               push;
   logic               pop;
   q_entry_type        push_entry;
   q_entry_type        head;
   q_status_type       q_status;

   // configuration registers; a new phase length applies from the next phase
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff    <= PHASE_TICKS_RST;
         ack_poll_limit_ff <= ACK_POLL_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_TICKS:    phase_ticks_ff    <= csr_wdata[PHASE_W-1:0];
            CSR_ACK_POLL_LIMIT: ack_poll_limit_ff <= csr_wdata[POLL_W-1:0];
            default: begin
               // hold: index outside the register map
            end
         endcase
      end
   end

   assign cfg.phase_ticks    = phase_ticks_ff;
   assign cfg.ack_poll_limit = ack_poll_limit_ff;

   // classify incoming ticks
   i2cbe_front u_front (
      .req_ch     (req_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple intake from the sequencer
   i2cbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_status   (q_status),
      .head       (head)
   );

   // advance the bus sequence, one tick per entry
   i2cbe_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_status.valid),
      .head    (head),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
